FILE: rtl/core/assert_macros.svh
// Assertion macros shared by the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion, disabled while rst is high.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Implication form of ASSERT_CLK.
`define ASSERT_IMPL(label, cond, prop, msg) \
  `ASSERT_CLK(label, (cond) |-> (prop), msg)
`endif

FILE: rtl/core/ttim_pkg.sv
// Shared types and constants for the tensor transpose index map.
package ttim_pkg;
  localparam int NDIM  = 4;
  localparam int IDX_W = 24;
  localparam int SZ_W  = 13;
  localparam int REG_W = 3;

  localparam logic [REG_W-1:0] REG_RANK   = 3'd0;
  localparam logic [REG_W-1:0] REG_SIZE0  = 3'd1;
  localparam logic [REG_W-1:0] REG_SIZE1  = 3'd2;
  localparam logic [REG_W-1:0] REG_SIZE2  = 3'd3;
  localparam logic [REG_W-1:0] REG_SIZE3  = 3'd4;
  localparam logic [REG_W-1:0] REG_FIRST  = 3'd5;
  localparam logic [REG_W-1:0] REG_SECOND = 3'd6;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_AXIS  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef logic [SZ_W-1:0] size_t;

  typedef struct packed {
    size_t c3;
    size_t c2;
    logic  axis_bad;
  } side_t;

  typedef struct packed {
    size_t [NDIM-1:0] e;
    size_t [NDIM-1:0] ep;
    logic  [1:0]      pa;
    logic  [1:0]      pb;
    logic             zero;
  } shape_t;
endpackage

FILE: rtl/core/ttim_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband.
module ttim_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [ttim_pkg::IDX_W-1:0]  dividend,
  input  ttim_pkg::size_t             divisor,
  input  ttim_pkg::side_t             in_side,
  output logic                        out_valid,
  output logic [ttim_pkg::IDX_W-1:0]  quot,
  output ttim_pkg::size_t             rem,
  output ttim_pkg::side_t             out_side
);
  localparam int N = ttim_pkg::IDX_W;

  logic [N-1:0]                      v;
  logic [N-1:0][N-1:0]               w;
  ttim_pkg::size_t [N-1:0]           r;
  ttim_pkg::side_t [N-1:0]           sd;
  logic [N-1:0][N-1:0]               w_next;
  ttim_pkg::size_t [N-1:0]           r_next;

  always_comb begin
    logic [N-1:0]           wi;
    ttim_pkg::size_t        ri;
    logic [ttim_pkg::SZ_W:0] t;
    for (int k = 0; k < N; k++) begin
      wi = (k == 0) ? dividend : w[(k == 0) ? 0 : k-1];
      ri = (k == 0) ? '0 : r[(k == 0) ? 0 : k-1];
      t = {ri, wi[N-1]};
      if (t >= {1'b0, divisor}) begin
        r_next[k] = ttim_pkg::SZ_W'(t - {1'b0, divisor});
        w_next[k] = {wi[N-2:0], 1'b1};
      end else begin
        r_next[k] = t[ttim_pkg::SZ_W-1:0];
        w_next[k] = {wi[N-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[N-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w  <= w_next;
      r  <= r_next;
      sd <= {sd[N-2:0], in_side};
    end
  end

  assign out_valid = v[N-1];
  assign quot      = w[N-1];
  assign rem       = r[N-1];
  assign out_side  = sd[N-1];
endmodule

FILE: rtl/core/ttim_recombine.sv
// Status, coordinate swap and Horner recombination stages.
module ttim_recombine (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [ttim_pkg::IDX_W-1:0]  c0,
  input  ttim_pkg::size_t             c1,
  input  ttim_pkg::side_t             side,
  input  ttim_pkg::shape_t            shape,
  output logic                        out_valid,
  output logic [ttim_pkg::IDX_W-1:0]  dest,
  output logic [1:0]                  st
);
  localparam int MW = ttim_pkg::IDX_W + ttim_pkg::SZ_W;

  logic [3:0]                        v;
  logic [3:0][1:0]                   sts;
  ttim_pkg::size_t [ttim_pkg::NDIM-1:0] cs;
  ttim_pkg::size_t [ttim_pkg::NDIM-1:0] cin;
  ttim_pkg::size_t [ttim_pkg::NDIM-1:0] cs_next;
  logic [1:0]                        st_next;
  ttim_pkg::size_t                   c2d, c3d, c3e;
  logic [ttim_pkg::IDX_W-1:0]        acc1, acc2, acc3;
  logic [MW-1:0]                     m1, m2, m3;

  always_comb begin
    cin[0] = c0[ttim_pkg::SZ_W-1:0];
    cin[1] = c1;
    cin[2] = side.c2;
    cin[3] = side.c3;
    for (int k = 0; k < ttim_pkg::NDIM; k++) begin
      if (2'(k) == shape.pa) cs_next[k] = cin[shape.pb];
      else if (2'(k) == shape.pb) cs_next[k] = cin[shape.pa];
      else cs_next[k] = cin[k];
    end
    if (side.axis_bad) st_next = ttim_pkg::ST_AXIS;
    else if (shape.zero || (c0 >= ttim_pkg::IDX_W'(shape.e[0]))) st_next = ttim_pkg::ST_RANGE;
    else st_next = ttim_pkg::ST_OK;
  end

  assign m1 = MW'(cs[0]) * MW'(shape.ep[1]) + MW'(cs[1]);
  assign m2 = MW'(acc1) * MW'(shape.ep[2]) + MW'(c2d);
  assign m3 = MW'(acc2) * MW'(shape.ep[3]) + MW'(c3e);

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sts  <= {sts[2:0], st_next};
      cs   <= cs_next;
      acc1 <= m1[ttim_pkg::IDX_W-1:0];
      c2d  <= cs[2];
      c3d  <= cs[3];
      acc2 <= m2[ttim_pkg::IDX_W-1:0];
      c3e  <= c3d;
      acc3 <= (sts[2] == ttim_pkg::ST_OK) ? m3[ttim_pkg::IDX_W-1:0] : '0;
    end
  end

  assign out_valid = v[3];
  assign dest      = acc3;
  assign st        = sts[3];
endmodule

FILE: rtl/core/tensor_transpose_index_map_core.sv
// Top level of the tensor transpose index map.
// Maps a linear row-major source index to its index after two axes swap.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes rank,
// four sizes and the two axes; cfg_ready is always high. Write only while
// no word is in flight.
// Input channel: source_index words on in_valid/in_ready.
// Output channel: dest_index and status on out_valid/out_ready.
// One word per cycle sustained while out_ready is high. The path: an input
// register, three 24-stage pipelined dividers (one quotient bit per stage) that
// peel off the coordinates, then swap, status and three multiply-add
// stages that rebuild the destination index.
// The whole pipeline advances together: when the output word is held by
// out_ready low, in_ready drops and nothing moves, so nothing is lost.
// Reset clears all valid bits and sets rank 1, sizes 1, axes 0.
// Status: 0 ok, 1 axis outside rank, 2 index beyond element count.
module tensor_transpose_index_map_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ttim_pkg::REG_W-1:0]        cfg_index,
  input  logic [ttim_pkg::SZ_W-1:0]         cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [ttim_pkg::IDX_W-1:0]        source_index,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [ttim_pkg::IDX_W-1:0]        dest_index,
  output logic [1:0]                        status
);
`include "assert_macros.svh"

  logic [2:0]                           rank;
  ttim_pkg::size_t [ttim_pkg::NDIM-1:0] size;
  logic [1:0]                           first_axis, second_axis;
  logic [2:0]                           r_eff, off, di;
  logic                                 axis_bad;
  ttim_pkg::shape_t                     shape;
  logic                                 en;
  logic                                 a_valid;
  logic [ttim_pkg::IDX_W-1:0]           a_src;
  logic                                 a_bad;
  ttim_pkg::side_t                      a_side, s1, s2, s3;
  logic                                 v1, v2, v3;
  logic [ttim_pkg::IDX_W-1:0]           q1, q2, q3;
  ttim_pkg::size_t                      r1, r2, r3;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rank        <= 3'd1;
      size        <= {ttim_pkg::NDIM{ttim_pkg::SZ_W'(1)}};
      first_axis  <= '0;
      second_axis <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        ttim_pkg::REG_RANK:   rank        <= cfg_data[2:0];
        ttim_pkg::REG_SIZE0:  size[0]     <= cfg_data;
        ttim_pkg::REG_SIZE1:  size[1]     <= cfg_data;
        ttim_pkg::REG_SIZE2:  size[2]     <= cfg_data;
        ttim_pkg::REG_SIZE3:  size[3]     <= cfg_data;
        ttim_pkg::REG_FIRST:  first_axis  <= cfg_data[1:0];
        ttim_pkg::REG_SECOND: second_axis <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // pad to four dims with leading size-1 axes
  always_comb begin
    r_eff = (rank > 3'(ttim_pkg::NDIM)) ? 3'(ttim_pkg::NDIM) : rank;
    off = 3'(ttim_pkg::NDIM) - r_eff;
    axis_bad = ({1'b0, first_axis} >= r_eff) || ({1'b0, second_axis} >= r_eff);
    shape.pa = first_axis + off[1:0];
    shape.pb = second_axis + off[1:0];
    shape.zero = 1'b0;
    for (int k = 0; k < ttim_pkg::NDIM; k++) begin
      di = 3'(k) - off;
      shape.e[k] = (3'(k) >= off) ? size[di[1:0]] : ttim_pkg::SZ_W'(1);
      if (shape.e[k] == '0) shape.zero = 1'b1;
    end
    for (int k = 0; k < ttim_pkg::NDIM; k++) begin
      if (2'(k) == shape.pa) shape.ep[k] = shape.e[shape.pb];
      else if (2'(k) == shape.pb) shape.ep[k] = shape.e[shape.pa];
      else shape.ep[k] = shape.e[k];
    end
  end

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (en) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_src <= source_index;
      a_bad <= axis_bad;
    end
  end

  assign a_side = '{c3: '0, c2: '0, axis_bad: a_bad};

  ttim_div u_div3 (
    .clk(clk), .rst(rst), .en(en), .in_valid(a_valid), .dividend(a_src),
    .divisor(shape.e[3]), .in_side(a_side),
    .out_valid(v1), .quot(q1), .rem(r1), .out_side(s1)
  );

  always_comb begin
    s2 = s1;
    s2.c3 = r1;
  end

  ttim_div u_div2 (
    .clk(clk), .rst(rst), .en(en), .in_valid(v1), .dividend(q1),
    .divisor(shape.e[2]), .in_side(s2),
    .out_valid(v2), .quot(q2), .rem(r2), .out_side(s3)
  );

  ttim_pkg::side_t s4;
  always_comb begin
    s4 = s3;
    s4.c2 = r2;
  end

  ttim_pkg::side_t s5;
  ttim_div u_div1 (
    .clk(clk), .rst(rst), .en(en), .in_valid(v2), .dividend(q2),
    .divisor(shape.e[1]), .in_side(s4),
    .out_valid(v3), .quot(q3), .rem(r3), .out_side(s5)
  );

  ttim_recombine u_recombine (
    .clk(clk), .rst(rst), .en(en), .in_valid(v3), .c0(q3), .c1(r3),
    .side(s5), .shape(shape),
    .out_valid(out_valid), .dest(dest_index), .st(status)
  );

  `ASSERT_CLK(a_ready_rule, in_ready == (!out_valid || out_ready), "in_ready mismatch")
  `ASSERT_IMPL(a_err_zero, out_valid && (status != ttim_pkg::ST_OK), dest_index == '0, "nonzero dest on error")
  `ASSERT_IMPL(a_status_code, out_valid, (status == ttim_pkg::ST_OK) || (status == ttim_pkg::ST_AXIS) || (status == ttim_pkg::ST_RANGE), "bad status code")
endmodule
